FILE: rtl/core/zcgl_pkg.sv
package zcgl_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 11;
  localparam int IDX_W    = 4;
  localparam int FRAC_ONE = 1024;

  // Command codes as they arrive on the request channel
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_TOGGLE  = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;
  localparam logic [1:0] CMD_APPLY   = 2'd3;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_TOGGLE  = 2'd1,
    OP_RESTART = 2'd2,
    OP_APPLY   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_WAITING   = 2'd0,
    MODE_RECORDING = 2'd1,
    MODE_PLAYING   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    CFG_START_BASE    = 2'd0,
    CFG_START_SPREAD  = 2'd1,
    CFG_LENGTH_BASE   = 2'd2,
    CFG_LENGTH_SPREAD = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GRAIN_RD,
    ST_GRAIN_OUT,
    ST_PASS,
    ST_RECORD,
    ST_STOP,
    ST_MUL,
    ST_PROD,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_START_FIRST,
    ST_START_WALK,
    ST_END_FIRST,
    ST_END_WALK,
    ST_STORE,
    ST_RESTART
  } state_e;

  typedef struct packed {
    op_e                        op;
    logic signed [SAMPLE_W-1:0] sample;
  } req_t;

  // Head of the request queue as seen by the back end
  typedef struct packed {
    logic valid;
    req_t req;
  } q_head_t;

  typedef struct packed {
    logic [IDX_W-1:0]           grain_index;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       from_grain;
    logic                       last;
  } res_t;

endpackage

FILE: rtl/core/zcgl_intf.sv
interface zcgl_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [15:0] sample_in;

  modport source (output valid, command, sample_in, input ready);
  modport sink (input valid, command, sample_in, output ready);
endinterface

interface zcgl_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         grain_index;
  logic signed [15:0] sample_out;
  logic               from_grain;
  logic               last;

  modport source (output valid, grain_index, sample_out, from_grain, last, input ready);
  modport sink (input valid, grain_index, sample_out, from_grain, last, output ready);
endinterface

interface zcgl_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [10:0] data;

  modport source (output valid, reg_index, data, input ready);
  modport sink (input valid, reg_index, data, output ready);
endinterface

FILE: rtl/core/zcgl_front.sv
module zcgl_front import zcgl_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 command_i,
  input  logic signed [SAMPLE_W-1:0] sample_in_i,
  output q_head_t                    head_o,
  input  logic                       pop_i
);

  req_t       ent_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  req_t       req_new;
  logic       push;

  // Classify the command; the sample only matters on audio ticks
  always_comb begin
    req_new.sample = '0;
    case (command_i)
      CMD_TICK: begin
        req_new.op     = OP_TICK;
        req_new.sample = sample_in_i;
      end
      CMD_TOGGLE:  req_new.op = OP_TOGGLE;
      CMD_RESTART: req_new.op = OP_RESTART;
      CMD_APPLY:   req_new.op = OP_APPLY;
      default:     req_new.op = OP_TICK;
    endcase
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.req   = ent_q[rd_ptr_q];

  // Hold requests in a two-entry queue
  always_ff @(posedge clk_i) begin
    if (push) ent_q[wr_ptr_q] <= req_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop_i) rd_ptr_q <= !rd_ptr_q;
      case ({push, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: rtl/core/zcgl_div.sv
module zcgl_div #(
  parameter int DW    = 34,
  parameter int QW    = 20,
  parameter int SHIFT = 10,
  parameter int DIV   = 15
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  output logic          done_o,
  output logic [QW-1:0] quotient_o
);

  // Drop the power-of-two part by a shift, then divide the rest by DIV with a
  // rounded-up reciprocal; the product is exact for every shifted dividend
  localparam int XW  = DW - SHIFT;
  localparam int LW  = $clog2(DIV);
  localparam int S   = XW + LW;
  localparam int MW  = XW + 2;
  localparam int PRW = XW + MW;
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << S) + 64'(DIV) - 64'd1) / 64'(DIV));

  logic [XW-1:0]  x;
  logic [PRW-1:0] prod_q;
  logic           done_q;

  assign x = dividend_i[DW-1:SHIFT];

  // Multiply once per start; the quotient is ready in the cycle after start
  always_ff @(posedge clk_i) begin
    if (start_i) prod_q <= PRW'(x) * PRW'(RECIP);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = prod_q[S +: QW];

endmodule

FILE: rtl/core/zcgl_back.sv
module zcgl_back import zcgl_pkg::*; #(
  parameter int BUFFER_DEPTH = 1048576,
  parameter int GRAIN_COUNT  = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  q_head_t          head_i,
  output logic             pop_o,
  input  logic             cfg_valid_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output res_t             res_o
);

  localparam int AW    = $clog2(BUFFER_DEPTH);
  localparam int WPW   = $clog2(BUFFER_DEPTH + 1);
  localparam int MAW   = $clog2(2 * BUFFER_DEPTH);
  localparam int GW    = $clog2(GRAIN_COUNT);
  localparam int DEN   = FRAC_ONE * (GRAIN_COUNT - 1);
  localparam int NW    = $clog2(DEN + 1);
  localparam int RAW_W = CFG_W + GW + 1;
  localparam int PW    = NW + AW;

  state_e                state_q, state_d;
  mode_e                 mode_q, mode_d;
  logic                  have_loop_q, have_loop_d;
  logic                  bank_q, bank_d;
  logic [WPW-1:0]        wp_q, wp_d;
  logic [AW-1:0]         len_q, len_d;
  logic [AW-1:0]         pos_q [GRAIN_COUNT];
  logic [AW-1:0]         pos_d [GRAIN_COUNT];
  logic [AW-1:0]         beg_q [GRAIN_COUNT];
  logic [AW-1:0]         beg_d [GRAIN_COUNT];
  logic [AW-1:0]         fin_q [GRAIN_COUNT];
  logic [AW-1:0]         fin_d [GRAIN_COUNT];
  logic [GW-1:0]         gi_q, gi_d;
  logic                  phase_len_q, phase_len_d;
  logic                  restart_q, restart_d;
  req_t                  cur_q, cur_d;
  logic [NW-1:0]         num_q, num_d;
  logic [PW-1:0]         prod_q, prod_d;
  logic [AW-1:0]         s_q, s_d, es_q, es_d, ee_q, ee_d, walk_q, walk_d;
  logic                  flag_q, flag_d;
  logic [CFG_W-1:0]      sb_q, sb_d, ss_q, ss_d, lb_q, lb_d, ls_q, ls_d;
  logic                  out_valid_q, out_valid_d;
  res_t                  out_q, out_d;

  logic                  rd_en, wr_en, div_start, div_done;
  logic [AW-1:0]         rd_idx, wr_idx;
  logic [MAW-1:0]        rd_addr, wr_addr;
  logic signed [SAMPLE_W-1:0] rd_data_q;
  logic signed [SAMPLE_W-1:0] store_mem [2 * BUFFER_DEPTH];
  logic [AW-1:0]         quo;

  logic                  out_free, last_grain;
  logic [AW-1:0]         p_sel, e_val;
  logic [AW:0]           e_sum, nxt;
  logic [RAW_W-1:0]      num_raw;
  logic [WPW-1:0]        wp_next;

  zcgl_div #(
    .DW    (PW),
    .QW    (AW),
    .SHIFT ($clog2(FRAC_ONE)),
    .DIV   (GRAIN_COUNT - 1)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // Map a bank offset onto the memory: record bank is the one not played
  assign rd_addr = (bank_q ? MAW'(BUFFER_DEPTH) : MAW'(0)) + MAW'(rd_idx);
  assign wr_addr = (bank_q ? MAW'(0) : MAW'(BUFFER_DEPTH)) + MAW'(wr_idx);

  always_ff @(posedge clk_i) begin
    if (wr_en) store_mem[wr_addr] <= cur_q.sample;
    if (rd_en) rd_data_q <= store_mem[rd_addr];
  end

  assign out_free   = !out_valid_q || res_ready_i;
  assign last_grain = (gi_q == GW'(GRAIN_COUNT - 1));

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    have_loop_d = have_loop_q;
    bank_d      = bank_q;
    wp_d        = wp_q;
    len_d       = len_q;
    pos_d       = pos_q;
    beg_d       = beg_q;
    fin_d       = fin_q;
    gi_d        = gi_q;
    phase_len_d = phase_len_q;
    restart_d   = restart_q;
    cur_d       = cur_q;
    num_d       = num_q;
    prod_d      = prod_q;
    s_d         = s_q;
    es_d        = es_q;
    ee_d        = ee_q;
    walk_d      = walk_q;
    flag_d      = flag_q;
    sb_d        = sb_q;
    ss_d        = ss_q;
    lb_d        = lb_q;
    ls_d        = ls_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    pop_o       = 1'b0;
    rd_en       = 1'b0;
    rd_idx      = '0;
    wr_en       = 1'b0;
    wr_idx      = wp_q[AW-1:0];
    div_start   = 1'b0;
    p_sel       = '0;
    e_sum       = '0;
    e_val       = '0;
    nxt         = '0;
    num_raw     = '0;
    wp_next     = wp_q;

    // Drop the result once the receiver takes it
    if (out_valid_q && res_ready_i) out_valid_d = 1'b0;

    // Register writes
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_START_BASE:    sb_d = cfg_data_i;
        CFG_START_SPREAD:  ss_d = cfg_data_i;
        CFG_LENGTH_BASE:   lb_d = cfg_data_i;
        CFG_LENGTH_SPREAD: ls_d = cfg_data_i;
        default:           sb_d = sb_q;
      endcase
    end

    case (state_q)
      // Take the next request and dispatch it
      ST_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          cur_d = head_i.req;
          gi_d  = '0;
          case (head_i.req.op)
            OP_TOGGLE: begin
              if (mode_q == MODE_RECORDING) begin
                if (wp_q < WPW'(2)) mode_d = MODE_WAITING;
                else state_d = ST_STOP;
              end else begin
                mode_d = MODE_RECORDING;
                wp_d   = '0;
              end
            end
            OP_RESTART: begin
              if (mode_q == MODE_PLAYING) pos_d = beg_q;
            end
            OP_APPLY: begin
              if (mode_q == MODE_PLAYING) begin
                phase_len_d = 1'b0;
                restart_d   = 1'b0;
                state_d     = ST_MUL;
              end
            end
            OP_TICK: state_d = have_loop_q ? ST_GRAIN_RD : ST_PASS;
            default: state_d = ST_IDLE;
          endcase
        end
      end

      // Wrap the head, fetch its sample, advance
      ST_GRAIN_RD: begin
        p_sel      = (pos_q[gi_q] >= fin_q[gi_q]) ? beg_q[gi_q] : pos_q[gi_q];
        rd_en      = 1'b1;
        rd_idx     = p_sel;
        pos_d[gi_q] = p_sel + AW'(1);
        state_d    = ST_GRAIN_OUT;
      end

      ST_GRAIN_OUT: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.grain_index = IDX_W'(gi_q);
          out_d.sample      = rd_data_q;
          out_d.from_grain  = 1'b1;
          out_d.last        = last_grain;
          if (last_grain) begin
            state_d = ST_RECORD;
          end else begin
            gi_d    = gi_q + GW'(1);
            state_d = ST_GRAIN_RD;
          end
        end
      end

      ST_PASS: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.grain_index = '0;
          out_d.sample      = cur_q.sample;
          out_d.from_grain  = 1'b0;
          out_d.last        = 1'b1;
          state_d           = ST_RECORD;
        end
      end

      // While recording, write the tick's input; a full bank ends the take
      ST_RECORD: begin
        state_d = ST_IDLE;
        if (mode_q == MODE_RECORDING) begin
          if (wp_q < WPW'(BUFFER_DEPTH)) begin
            wr_en   = 1'b1;
            wp_next = wp_q + WPW'(1);
          end
          wp_d = wp_next;
          if (wp_next >= WPW'(BUFFER_DEPTH)) state_d = ST_STOP;
        end
      end

      ST_STOP: begin
        len_d       = AW'(wp_q - WPW'(1));
        bank_d      = !bank_q;
        have_loop_d = 1'b1;
        mode_d      = MODE_PLAYING;
        gi_d        = '0;
        phase_len_d = 1'b0;
        restart_d   = 1'b1;
        state_d     = ST_MUL;
      end

      // Fraction numerator, clamped to one
      ST_MUL: begin
        if (phase_len_q)
          num_raw = RAW_W'(lb_q) * RAW_W'(GRAIN_COUNT - 1) + RAW_W'(gi_q) * RAW_W'(ls_q);
        else
          num_raw = RAW_W'(sb_q) * RAW_W'(GRAIN_COUNT - 1) + RAW_W'(gi_q) * RAW_W'(ss_q);
        num_d   = (num_raw > RAW_W'(DEN)) ? NW'(DEN) : num_raw[NW-1:0];
        state_d = ST_PROD;
      end

      ST_PROD: begin
        prod_d  = PW'(num_q) * PW'(len_q);
        state_d = ST_DIV_GO;
      end

      ST_DIV_GO: begin
        div_start = 1'b1;
        state_d   = ST_DIV_WAIT;
      end

      ST_DIV_WAIT: begin
        if (div_done) begin
          if (!phase_len_q) begin
            s_d     = (quo >= len_q) ? len_q - AW'(1) : quo;
            es_d    = s_d;
            rd_en   = 1'b1;
            rd_idx  = s_d;
            state_d = ST_START_FIRST;
          end else begin
            e_sum = {1'b0, s_q} + {1'b0, quo};
            e_val = (e_sum >= {1'b0, len_q}) ? len_q - AW'(1) : e_sum[AW-1:0];
            if (e_val < AW'(2)) begin
              ee_d    = '0;
              state_d = ST_STORE;
            end else begin
              ee_d    = e_val - AW'(1);
              walk_d  = e_val - AW'(2);
              rd_en   = 1'b1;
              rd_idx  = e_val - AW'(1);
              state_d = ST_END_FIRST;
            end
          end
        end
      end

      // Walk forward to a negative-to-positive crossing
      ST_START_FIRST: begin
        flag_d = (rd_data_q < 0);
        nxt    = {1'b0, s_q} + (AW + 1)'(1);
        if (nxt < {1'b0, len_q}) begin
          walk_d  = nxt[AW-1:0];
          rd_en   = 1'b1;
          rd_idx  = nxt[AW-1:0];
          state_d = ST_START_WALK;
        end else begin
          phase_len_d = 1'b1;
          state_d     = ST_MUL;
        end
      end

      ST_START_WALK: begin
        if (flag_q && (rd_data_q > 0)) begin
          es_d        = walk_q;
          phase_len_d = 1'b1;
          state_d     = ST_MUL;
        end else begin
          flag_d = (rd_data_q < 0);
          nxt    = {1'b0, walk_q} + (AW + 1)'(1);
          if (nxt < {1'b0, len_q}) begin
            walk_d = nxt[AW-1:0];
            rd_en  = 1'b1;
            rd_idx = nxt[AW-1:0];
          end else begin
            phase_len_d = 1'b1;
            state_d     = ST_MUL;
          end
        end
      end

      // Walk backward to a positive-to-negative crossing above the start
      ST_END_FIRST: begin
        flag_d = (rd_data_q > 0);
        if (walk_q > es_q) begin
          rd_en   = 1'b1;
          rd_idx  = walk_q;
          state_d = ST_END_WALK;
        end else begin
          state_d = ST_STORE;
        end
      end

      ST_END_WALK: begin
        if (flag_q && (rd_data_q < 0)) begin
          ee_d    = walk_q;
          state_d = ST_STORE;
        end else begin
          flag_d = (rd_data_q > 0);
          e_val  = walk_q - AW'(1);
          if (e_val > es_q) begin
            walk_d = e_val;
            rd_en  = 1'b1;
            rd_idx = e_val;
          end else begin
            state_d = ST_STORE;
          end
        end
      end

      ST_STORE: begin
        beg_d[gi_q] = es_q;
        fin_d[gi_q] = ee_q;
        phase_len_d = 1'b0;
        if (last_grain) begin
          state_d = restart_q ? ST_RESTART : ST_IDLE;
        end else begin
          gi_d    = gi_q + GW'(1);
          state_d = ST_MUL;
        end
      end

      ST_RESTART: begin
        pos_d   = beg_q;
        state_d = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath registers without reset
  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    num_q  <= num_d;
    prod_q <= prod_d;
    s_q    <= s_d;
    es_q   <= es_d;
    ee_q   <= ee_d;
    walk_q <= walk_d;
    flag_q <= flag_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_WAITING;
      have_loop_q <= 1'b0;
      bank_q      <= 1'b0;
      wp_q        <= '0;
      len_q       <= '0;
      gi_q        <= '0;
      phase_len_q <= 1'b0;
      restart_q   <= 1'b0;
      sb_q        <= '0;
      ss_q        <= '0;
      lb_q        <= '0;
      ls_q        <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < GRAIN_COUNT; i++) begin
        pos_q[i] <= '0;
        beg_q[i] <= '0;
        fin_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      have_loop_q <= have_loop_d;
      bank_q      <= bank_d;
      wp_q        <= wp_d;
      len_q       <= len_d;
      gi_q        <= gi_d;
      phase_len_q <= phase_len_d;
      restart_q   <= restart_d;
      sb_q        <= sb_d;
      ss_q        <= ss_d;
      lb_q        <= lb_d;
      ls_q        <= ls_d;
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
      beg_q       <= beg_d;
      fin_q       <= fin_d;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

FILE: rtl/core/zero_crossing_grain_looper_top.sv
// Grain looper with zero-crossing snapped grain bounds.
// in_chan carries one request per handshake: command (audio tick, toggle
// recording, restart grains, apply settings) and a Q15 input sample.
// out_chan returns results: one passthrough sample per tick before a loop
// exists, then GRAIN_COUNT grain samples per tick, the final one flagged last.
// cfg_chan writes the four placement registers; it is always ready.
// Requests enter a two-entry queue and are executed one at a time.
// A tick with a loop passes through dispatch, one read and one output slot
// per grain, and one write slot; a passthrough tick passes through dispatch,
// one output slot and one write slot. An output slot waits while the result
// register is still held by a stalled receiver.
// Stopping a take or applying settings while playing places every grain: each
// grain takes two offsets by multiply and reciprocal multiply, and each offset
// is snapped by walking samples of the played bank.
// Reset clears mode, loop, heads and registers; the sample memory is not
// cleared. When the receiver stalls, the result register holds and the
// engine waits; new requests keep queuing until the queue fills.
module zero_crossing_grain_looper_top import zcgl_pkg::*; #(
  parameter int BUFFER_DEPTH = 1048576,
  parameter int GRAIN_COUNT  = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  zcgl_in_if.sink    in_chan,
  zcgl_out_if.source out_chan,
  zcgl_cfg_if.sink   cfg_chan
);

  q_head_t head;
  logic    pop;
  res_t    res;

  zcgl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_chan.valid),
    .in_ready_o  (in_chan.ready),
    .command_i   (in_chan.command),
    .sample_in_i (in_chan.sample_in),
    .head_o      (head),
    .pop_i       (pop)
  );

  zcgl_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .GRAIN_COUNT  (GRAIN_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .cfg_valid_i (cfg_chan.valid),
    .cfg_index_i (cfg_chan.reg_index),
    .cfg_data_i  (cfg_chan.data),
    .res_valid_o (out_chan.valid),
    .res_ready_i (out_chan.ready),
    .res_o       (res)
  );

  assign cfg_chan.ready       = 1'b1;
  assign out_chan.grain_index = res.grain_index;
  assign out_chan.sample_out  = res.sample;
  assign out_chan.from_grain  = res.from_grain;
  assign out_chan.last        = res.last;

endmodule

FILE: rtl/core/zcgl_checker.sv
module zcgl_checker #(
  parameter int GRAIN_COUNT = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [3:0]  grain_index_i,
  input logic [15:0] sample_out_i,
  input logic        from_grain_i,
  input logic        last_i
);

  logic out_acc;
  assign out_acc = out_valid_i && out_ready_i;

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({grain_index_i, sample_out_i, from_grain_i, last_i}))
    else $error("result changed while stalled");

  // Grains of one tick come out in order
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && from_grain_i && !last_i |=> !out_valid_i ||
      (from_grain_i && grain_index_i == $past(grain_index_i) + 4'd1))
    else $error("grain order broken");

  // Passthrough is a single, final result from grain zero
  a_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !from_grain_i |-> last_i && grain_index_i == 4'd0)
    else $error("bad passthrough result");

  // Last grain result closes the tick
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && from_grain_i && last_i |-> grain_index_i == 4'(GRAIN_COUNT - 1))
    else $error("tick closed at wrong grain");

endmodule

bind zero_crossing_grain_looper_top zcgl_checker #(.GRAIN_COUNT(GRAIN_COUNT)) u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_chan.valid),
  .out_ready_i   (out_chan.ready),
  .grain_index_i (out_chan.grain_index),
  .sample_out_i  (out_chan.sample_out),
  .from_grain_i  (out_chan.from_grain),
  .last_i        (out_chan.last)
);
